### rtl/rppw_pkg.sv
// ----------------------------------------------------------------------------
// rppw_pkg
// types and codes shared by the rotated pixel plane writer
// ----------------------------------------------------------------------------
package rppw_pkg;

  // width of signed coordinate arithmetic
  localparam int unsigned CW = 18;

  localparam logic [1:0] ACT_PLOT   = 2'd0;
  localparam logic [1:0] ACT_INVERT = 2'd1;
  localparam logic [1:0] ACT_READ   = 2'd2;

  localparam logic [2:0] REG_ORIENT  = 3'd0;
  localparam logic [2:0] REG_CWIDTH  = 3'd1;
  localparam logic [2:0] REG_CHEIGHT = 3'd2;
  localparam logic [2:0] REG_WLEFT   = 3'd3;
  localparam logic [2:0] REG_WRIGHT  = 3'd4;
  localparam logic [2:0] REG_RFIRST  = 3'd5;
  localparam logic [2:0] REG_RLAST   = 3'd6;
  localparam logic [2:0] REG_REDEN   = 3'd7;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [1:0]         pixel_color;
    logic [13:0]        byte_index;
  } cmd_t;

  typedef struct packed {
    logic [7:0] black_byte;
    logic [7:0] red_byte;
    logic       written;
  } result_t;

endpackage

### rtl/rotated_pixel_plane_writer_unit.sv
// ----------------------------------------------------------------------------
// rotated_pixel_plane_writer_unit
// two-plane 1-bit page store with rotating, flipping and clipping pixel plot
// ----------------------------------------------------------------------------
// usage:
//   a command transaction is taken when start is high and busy is low.
//   actions: plot one pixel, invert the black plane, read one byte of both
//   planes. every command gives exactly one result, shown on result_o for
//   one cycle with result_valid_o high; the receiver cannot stall it.
//   configuration lives behind an apb-style port, register i at byte 4*i,
//   pready always high, writes land in the access cycle.
// timing:
//   each command walks a fixed sequencer: transform and clip, multiply,
//   offset add and bound check, memory read, modify and write back.
//   the result strobe comes with the return to idle and busy drops in that
//   same cycle, so a new command is taken only after the last one is done. the
//   single read-modify-write pass over the plane memories sets this pace.
//   invert toggles a polarity flag on the black plane and takes the same time.
// reset:
//   after reset the block sweeps both planes to zero, one byte a cycle,
//   with busy high throughout; config writes are taken meanwhile.
// ----------------------------------------------------------------------------
module rotated_pixel_plane_writer_unit
  import rppw_pkg::*;
#(
  parameter int unsigned PAGE_BYTES = 16384
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  cmd_t        cmd_i,
  output logic        result_valid_o,
  output result_t     result_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned AW = $clog2(PAGE_BYTES);
  localparam logic [AW-1:0] CLR_LAST = AW'(PAGE_BYTES - 1);
  localparam logic [19:0]   PAGE_LIM = 20'(PAGE_BYTES);
  localparam logic [16:0]   IDX_LIM  = 17'(PAGE_BYTES);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_CALC, S_MUL, S_SUM, S_RD, S_RES
  } state_e;

  state_e state_q;
  logic [AW-1:0] clr_q;
  logic inv_q;
  logic result_valid_q;
  result_t result_q;

  // configuration
  logic [3:0]  orient_q;
  logic [10:0] cw_q, ch_q;
  logic [9:0]  wl_q, wr_q, rf_q, rl_q;
  logic        red_en_q;

  // work registers
  cmd_t        cmd_q;
  logic [9:0]  x_q, y_q;
  logic        ok_q;
  logic [17:0] prod_q;
  logic [6:0]  col_q;
  logic [19:0] off_q;

  // memories
  logic [7:0] blk_mem [PAGE_BYTES];
  logic [7:0] red_mem [PAGE_BYTES];
  logic [7:0] blk_rd_q, red_rd_q;
  logic          blk_we, red_we;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    blk_wdata, red_wdata;

  logic accept;
  logic cfg_we;
  assign accept = start && (state_q == S_IDLE);
  assign busy   = (state_q != S_IDLE);
  assign cfg_we = psel && penable && pwrite;
  assign pready = 1'b1;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      orient_q <= 4'd0;
      cw_q     <= 11'd200;
      ch_q     <= 11'd200;
      wl_q     <= 10'd0;
      wr_q     <= 10'd199;
      rf_q     <= 10'd0;
      rl_q     <= 10'd199;
      red_en_q <= 1'b0;
    end else if (cfg_we) begin
      case (paddr[4:2])
        REG_ORIENT:  orient_q <= pwdata[3:0];
        REG_CWIDTH:  cw_q     <= pwdata[10:0];
        REG_CHEIGHT: ch_q     <= pwdata[10:0];
        REG_WLEFT:   wl_q     <= pwdata[9:0];
        REG_WRIGHT:  wr_q     <= pwdata[9:0];
        REG_RFIRST:  rf_q     <= pwdata[9:0];
        REG_RLAST:   rl_q     <= pwdata[9:0];
        REG_REDEN:   red_en_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_ORIENT:  prdata = {28'd0, orient_q};
      REG_CWIDTH:  prdata = {21'd0, cw_q};
      REG_CHEIGHT: prdata = {21'd0, ch_q};
      REG_WLEFT:   prdata = {22'd0, wl_q};
      REG_WRIGHT:  prdata = {22'd0, wr_q};
      REG_RFIRST:  prdata = {22'd0, rf_q};
      REG_RLAST:   prdata = {22'd0, rl_q};
      REG_REDEN:   prdata = {31'd0, red_en_q};
      default:     prdata = 32'd0;
    endcase
  end

  // rotate, flip and clip
  logic signed [CW-1:0] wm, hm, px, py, xr, yr, xh, yh, xv, yv;
  logic clip_ok;
  logic land;
  always_comb begin
    wm = $signed({7'd0, cw_q}) - 18'sd1;
    hm = $signed({7'd0, ch_q}) - 18'sd1;
    px = {{2{cmd_q.pos_x[15]}}, cmd_q.pos_x};
    py = {{2{cmd_q.pos_y[15]}}, cmd_q.pos_y};
    land = orient_q[0];
    case (orient_q[1:0])
      2'd0: begin
        xr = px;
        yr = py;
      end
      2'd1: begin
        xr = wm - py;
        yr = px;
      end
      2'd2: begin
        xr = wm - px;
        yr = hm - py;
      end
      default: begin
        xr = py;
        yr = hm - px;
      end
    endcase
    xh = xr;
    yh = yr;
    if (orient_q[2]) begin
      if (land) yh = hm - yr;
      else      xh = wm - xr;
    end
    xv = xh;
    yv = yh;
    if (orient_q[3]) begin
      if (land) xv = wm - xh;
      else      yv = hm - yh;
    end
    clip_ok = !xv[CW-1] && !yv[CW-1]
           && (xv >= $signed({8'd0, wl_q})) && (xv <= $signed({8'd0, wr_q}))
           && (yv >= $signed({8'd0, rf_q})) && (yv <= $signed({8'd0, rl_q}));
  end

  // byte offset
  logic [10:0] span;
  logic [9:0]  row, colv;
  logic [17:0] prod;
  logic [19:0] off;
  always_comb begin
    span = {1'b0, wr_q} - {1'b0, wl_q} + 11'd1;
    row  = y_q - rf_q;
    colv = x_q - wl_q;
    prod = {8'd0, row} * {10'd0, span[10:3]};
    off  = {2'd0, prod_q} + {13'd0, col_q};
  end

  // work registers, no reset
  always_ff @(posedge clk_i) begin
    if (accept) cmd_q <= cmd_i;
    case (state_q)
      S_CALC: begin
        x_q  <= xv[9:0];
        y_q  <= yv[9:0];
        ok_q <= clip_ok;
      end
      S_MUL: begin
        prod_q <= prod;
        col_q  <= colv[9:3];
      end
      S_SUM: begin
        off_q <= off;
        ok_q  <= ok_q && (off < PAGE_LIM);
      end
      default: ;
    endcase
  end

  // modify
  logic [7:0] mask, blk_old, blk_new, red_new;
  logic       idx_ok, plot_we;
  result_t    res_d;
  always_comb begin
    mask    = 8'h80 >> x_q[2:0];
    blk_old = blk_rd_q ^ {8{inv_q}};
    blk_new = (blk_old & ~mask) | (cmd_q.pixel_color[0] ? mask : 8'd0);
    red_new = (red_rd_q & ~mask) | (cmd_q.pixel_color[1] ? mask : 8'd0);
    idx_ok  = {3'd0, cmd_q.byte_index} < IDX_LIM;
    plot_we = (state_q == S_RES) && (cmd_q.action == ACT_PLOT) && ok_q;
    res_d   = '0;
    case (cmd_q.action)
      ACT_PLOT: res_d.written = ok_q;
      ACT_READ: begin
        if (idx_ok) begin
          res_d.black_byte = blk_old;
          res_d.red_byte   = red_rd_q;
        end
      end
      default: ;
    endcase
  end

  // memory ports
  always_comb begin
    raddr = (cmd_q.action == ACT_READ) ? AW'(cmd_q.byte_index) : AW'(off_q);
    if (state_q == S_CLEAR) begin
      blk_we    = 1'b1;
      red_we    = 1'b1;
      waddr     = clr_q;
      blk_wdata = 8'd0;
      red_wdata = 8'd0;
    end else begin
      blk_we    = plot_we;
      red_we    = plot_we && red_en_q;
      waddr     = AW'(off_q);
      blk_wdata = blk_new ^ {8{inv_q}};
      red_wdata = red_new;
    end
  end

  always_ff @(posedge clk_i) begin
    if (blk_we) blk_mem[waddr] <= blk_wdata;
    blk_rd_q <= blk_mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (red_we) red_mem[waddr] <= red_wdata;
    red_rd_q <= red_mem[raddr];
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_CLEAR;
      clr_q          <= '0;
      inv_q          <= 1'b0;
      result_valid_q <= 1'b0;
      result_q       <= '0;
    end else begin
      result_valid_q <= (state_q == S_RES);
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == CLR_LAST) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (start) state_q <= S_CALC;
        end
        S_CALC: state_q <= S_MUL;
        S_MUL:  state_q <= S_SUM;
        S_SUM:  state_q <= S_RD;
        S_RD:   state_q <= S_RES;
        S_RES: begin
          if (cmd_q.action == ACT_INVERT) inv_q <= ~inv_q;
          result_q <= res_d;
          state_q  <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

endmodule
